[sv/skf_pkg.sv]
// ============================================================================
// skf_pkg
// Shared widths, reset constants, register indexes and types for the scalar
// Kalman filter and its iterative gain divider.
// ============================================================================
package skf_pkg;

    // Sample format: signed fixed point, DATA_WIDTH bits
    localparam int DATA_WIDTH    = 32;
    // Covariance format: unsigned 32 bits, COV_FRAC_BITS fraction bits
    localparam int COV_FRAC_BITS = 24;
    localparam int COV_W         = 32;

    // Stream data width, padded to whole bytes
    localparam int TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;

    // Gain datapath widths
    localparam int DEN_W   = COV_W + 1;                  // Pp + R
    localparam int NUM_W   = COV_W + COV_FRAC_BITS + 1;  // (Pp << F) + den/2
    localparam int GAIN_W  = COV_FRAC_BITS + 1;          // Q1.F, up to 1.0
    localparam int CNT_W   = $clog2(GAIN_W + 1);

    // Shared multiplier widths
    localparam int MAG_W   = DATA_WIDTH + 1;             // |innovation|
    localparam int MUL_B_W = (MAG_W > COV_W) ? MAG_W : COV_W;
    localparam int PROD_W  = GAIN_W + MUL_B_W;

    // Reset values, rounded to nearest
    localparam longint unsigned COV_ONE_L = 64'd1 << COV_FRAC_BITS;
    localparam logic [COV_W-1:0] P_RESET = COV_W'((COV_ONE_L * 2 + 50) / 100);
    localparam logic [COV_W-1:0] Q_RESET = COV_W'((COV_ONE_L + 500) / 1000);
    localparam logic [COV_W-1:0] R_RESET = COV_W'((COV_ONE_L * 543 + 500) / 1000);

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MEASUREMENT_NOISE = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_MUL_EST,
        S_MUL_COV,
        S_DONE
    } skf_state_t;

    // Divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } skf_div_stat_t;

endpackage

[sv/skf_div.sv]
// ============================================================================
// skf_div
// Restoring divider for the Kalman gain: one quotient bit per cycle through a
// single compare-and-subtract unit. Quotient must fit in GAIN_W bits.
// ============================================================================
module skf_div
    import skf_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [NUM_W-1:0]    num,
    input  logic [DEN_W-1:0]    den,
    output logic [GAIN_W-1:0]   quot,
    output skf_div_stat_t       stat
);

    logic [DEN_W-1:0]  rem_reg,  rem_next;
    logic [DEN_W-1:0]  den_reg,  den_next;
    logic [GAIN_W-1:0] low_reg,  low_next;
    logic [GAIN_W-1:0] quot_reg, quot_next;
    logic [CNT_W-1:0]  cnt_reg,  cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [DEN_W:0]    shifted;
    logic [DEN_W+1:0]  diff;
    logic              ge;

    // Shared compare-and-subtract step
    always_comb begin
        shifted = {rem_reg, low_reg[GAIN_W-1]};
        diff    = {1'b0, shifted} - {2'b00, den_reg};
        ge      = ~diff[DEN_W+1];
    end

    // Step control
    always_comb begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        low_next  = low_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            // Upper numerator bits are already below the divisor
            rem_next  = DEN_W'(num[NUM_W-1:GAIN_W]);
            low_next  = num[GAIN_W-1:0];
            den_next  = den;
            quot_next = '0;
            cnt_next  = CNT_W'(GAIN_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
            low_next  = {low_reg[GAIN_W-2:0], 1'b0};
            quot_next = {quot_reg[GAIN_W-2:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        low_reg  <= low_next;
        quot_reg <= quot_next;
    end

    assign quot      = quot_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

    // Checks
    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> busy_reg)
        else $error("divider did not start");
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg)
        else $error("divider done while busy");
    a_busy_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (cnt_reg != '0))
        else $error("divider busy with empty step count");

endmodule

[sv/scalar_kalman_filter.sv]
// ============================================================================
// scalar_kalman_filter
// One-dimensional Kalman filter for a single sensor channel.
// ============================================================================
// Each measurement transfer (signed Q16.16) yields one estimate transfer. The
// sequencer predicts Pp = P + Q (saturating), forms the gain Pp / (Pp + R) on a
// restoring divider at one quotient bit per cycle (zero gain, with no division,
// when Pp + R is zero), then runs one shared multiplier twice: gain times
// innovation for the estimate, and (1 - gain) times Pp for the new covariance.
// The steps are prediction, the divider steps, pick-up of the quotient, the two
// multiplies and write-back. s_tready is high only while the sequencer is idle,
// so a new item is accepted only after the result of the last one is loaded. The
// result waits in an output register; a stalled m_tready holds the next item at
// its final write-back. Q and R must be written on the cfg port only while the
// block is idle; the block itself does not enforce it. Reset loads Q = 0.001,
// R = 0.543, P = 0.02 and a zero estimate.
// ============================================================================
module scalar_kalman_filter
    import skf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // Measurement stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [TDATA_W-1:0]   s_tdata,   // [DATA_WIDTH-1:0] measurement
    // Estimate stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [TDATA_W-1:0]   m_tdata,   // [DATA_WIDTH-1:0] estimate
    // Configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COV_W-1:0]     cfg_data
);

    localparam logic [GAIN_W-1:0] GAIN_ONE   = GAIN_W'(1) << COV_FRAC_BITS;
    localparam logic [PROD_W:0]   ROUND_HALF = (PROD_W + 1)'(1) << (COV_FRAC_BITS - 1);
    // Signed estimate limits
    localparam logic signed [DATA_WIDTH-1:0] EST_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] EST_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    skf_state_t state_reg, state_next;

    logic        [COV_W-1:0]      q_reg,       q_next;
    logic        [COV_W-1:0]      r_reg,       r_next;
    logic        [COV_W-1:0]      cov_reg,     cov_next;
    logic signed [DATA_WIDTH-1:0] est_reg,     est_next;
    logic signed [DATA_WIDTH-1:0] meas_reg,    meas_next;
    logic        [COV_W-1:0]      pp_reg,      pp_next;
    logic        [GAIN_W-1:0]     gain_reg,    gain_next;
    logic        [MAG_W-1:0]      mag_reg,     mag_next;
    logic                         neg_reg,     neg_next;
    logic signed [DATA_WIDTH-1:0] new_est_reg, new_est_next;
    logic        [PROD_W-1:0]     prod_reg,    prod_next;
    logic                         out_valid_reg, out_valid_next;
    logic signed [DATA_WIDTH-1:0] out_data_reg,  out_data_next;

    // Prediction and division operands
    logic [COV_W:0]        pp_sum;
    logic [COV_W-1:0]      pp_c;
    logic [DEN_W-1:0]      den_c;
    logic [NUM_W-1:0]      num_c;
    logic signed [MAG_W-1:0] inn_c;
    logic                  div_start;
    logic [GAIN_W-1:0]     div_quot;
    skf_div_stat_t         div_stat;

    // Shared multiplier
    logic [GAIN_W-1:0]     mul_a;
    logic [MUL_B_W-1:0]    mul_b;
    logic [PROD_W-1:0]     mul_p;

    // Write-back arithmetic
    logic [PROD_W:0]            rnd_sum;
    logic [MAG_W-1:0]           delta_c;
    logic signed [MAG_W:0]      est_sum;
    logic signed [MAG_W:0]      est_ext;
    logic signed [DATA_WIDTH-1:0] est_sat;
    logic                       out_free;

    skf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (num_c),
        .den     (den_c),
        .quot    (div_quot),
        .stat    (div_stat)
    );

    // Prediction: Pp, Pp + R, rounded numerator, innovation
    always_comb begin
        pp_sum = {1'b0, cov_reg} + {1'b0, q_reg};
        pp_c   = pp_sum[COV_W] ? {COV_W{1'b1}} : pp_sum[COV_W-1:0];
        den_c  = {1'b0, pp_c} + {1'b0, r_reg};
        num_c  = {1'b0, pp_c, {COV_FRAC_BITS{1'b0}}} + NUM_W'(den_c[DEN_W-1:1]);
        inn_c  = MAG_W'(meas_reg) - MAG_W'(est_reg);
    end

    // Operand select for the shared multiplier
    always_comb begin
        if (state_reg == S_MUL_EST) begin
            mul_a = gain_reg;
            mul_b = MUL_B_W'(mag_reg);
        end else begin
            mul_a = GAIN_ONE - gain_reg;
            mul_b = MUL_B_W'(pp_reg);
        end
        mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // Rounding, signed update and saturation
    always_comb begin
        rnd_sum = {1'b0, prod_reg} + ROUND_HALF;
        delta_c = rnd_sum[COV_FRAC_BITS +: MAG_W];
        est_ext = (MAG_W + 1)'(est_reg);
        if (neg_reg) begin
            est_sum = est_ext - $signed({1'b0, delta_c});
        end else begin
            est_sum = est_ext + $signed({1'b0, delta_c});
        end
        if (est_sum > (MAG_W + 1)'(EST_MAX)) begin
            est_sat = EST_MAX;
        end else if (est_sum < (MAG_W + 1)'(EST_MIN)) begin
            est_sat = EST_MIN;
        end else begin
            est_sat = est_sum[DATA_WIDTH-1:0];
        end
    end

    // Sequencer: next state and datapath loads
    always_comb begin
        state_next     = state_reg;
        q_next         = q_reg;
        r_next         = r_reg;
        cov_next       = cov_reg;
        est_next       = est_reg;
        meas_next      = meas_reg;
        pp_next        = pp_reg;
        gain_next      = gain_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        new_est_next   = new_est_reg;
        prod_next      = prod_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        div_start      = 1'b0;
        out_free       = !out_valid_reg || m_tready;

        // Output slot empties on a transfer
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        // Register writes
        if (cfg_valid) begin
            case (cfg_index)
                REG_PROCESS_NOISE:     q_next = cfg_data;
                REG_MEASUREMENT_NOISE: r_next = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    meas_next  = s_tdata[DATA_WIDTH-1:0];
                    state_next = S_PREP;
                end
            end
            S_PREP: begin
                pp_next  = pp_c;
                neg_next = inn_c[MAG_W-1];
                mag_next = inn_c[MAG_W-1] ? MAG_W'(-inn_c) : MAG_W'(inn_c);
                if (den_c == '0) begin
                    // No uncertainty at all: zero gain
                    gain_next  = '0;
                    state_next = S_MUL_EST;
                end else begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                if (div_stat.done) begin
                    gain_next  = (div_quot > GAIN_ONE) ? GAIN_ONE : div_quot;
                    state_next = S_MUL_EST;
                end
            end
            S_MUL_EST: begin
                prod_next  = mul_p;
                state_next = S_MUL_COV;
            end
            S_MUL_COV: begin
                new_est_next = est_sat;
                prod_next    = mul_p;
                state_next   = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    est_next       = new_est_reg;
                    out_data_next  = new_est_reg;
                    out_valid_next = 1'b1;
                    cov_next       = rnd_sum[COV_FRAC_BITS +: COV_W];
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Filter state, registers and datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg         <= Q_RESET;
            r_reg         <= R_RESET;
            cov_reg       <= P_RESET;
            est_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            q_reg         <= q_next;
            r_reg         <= r_next;
            cov_reg       <= cov_next;
            est_reg       <= est_next;
            out_valid_reg <= out_valid_next;
        end
        meas_reg     <= meas_next;
        pp_reg       <= pp_next;
        gain_reg     <= gain_next;
        mag_reg      <= mag_next;
        neg_reg      <= neg_next;
        new_est_reg  <= new_est_next;
        prod_reg     <= prod_next;
        out_data_reg <= out_data_next;
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = TDATA_W'($unsigned(out_data_reg));

    // Checks
    a_accept_prep: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == S_PREP))
        else $error("accepted item did not enter prediction");
    a_div_active: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |-> (div_stat.busy || div_stat.done))
        else $error("waiting on an idle divider");
    a_gain_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MUL_EST) |-> (gain_reg <= GAIN_ONE))
        else $error("gain above one");

endmodule
